// File: rtl/core/hld_pkg.sv
// Shared types, constants and helper function of the hex line decoder.
`default_nettype none
package hld_pkg;

	localparam int unsigned MAX_BYTES_DEF  = 64;
	localparam int unsigned CFG_W          = 7;
	localparam logic [CFG_W-1:0] BYTE_COUNT_RST = 7'd20;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] TEN      = 8'd10;

	typedef enum logic [2:0] {
		ST_SCAN,
		ST_DECIDE,
		ST_READ,
		ST_LOAD,
		ST_SKIP
	} hld_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic scan;
		logic clear;
		logic rd_en;
		logic load_byte;
		logic load_skip;
	} hld_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic empty;
		logic match;
		logic out_free;
		logic rd_last;
	} hld_stat_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] nib;
	} hex_digit_t;

	function automatic hex_digit_t hex_value(input logic [7:0] c);
		hex_digit_t r;
		logic [7:0] v;
		r = '0;
		v = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c - CH_ZERO;
			r.is_hex = 1'b1;
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			v = TEN + c - CH_UP_A;
			r.is_hex = 1'b1;
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			v = TEN + c - CH_LO_A;
			r.is_hex = 1'b1;
		end
		r.nib = v[3:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/hld_if.sv
// Valid/ready channel interfaces of the hex line decoder.
`default_nettype none
interface hld_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       line_last;
	modport source (output valid, output ch, output line_last, input ready);
	modport sink   (input valid, input ch, input line_last, output ready);
endinterface

interface hld_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       status;
	logic       last;
	modport source (output valid, output data_byte, output status, output last, input ready);
	modport sink   (input valid, input data_byte, input status, input last, output ready);
endinterface

interface hld_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] byte_count;
	modport source (output valid, output byte_count, input ready);
	modport sink   (input valid, input byte_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/hex_line_to_binary_decoder.sv
// Top level of the hex line decoder: channels, configuration register, controller and datapath.
`default_nettype none
// Decodes hex text, one character per request on text_in, into bytes on byte_out.
// Hex digits of either case pair into bytes, high nibble first; space and tab are
// skipped; LF, VT, FF, CR or NUL ends the scan of the line; any other character,
// an odd digit count or more than byte_count or MAX_BYTES bytes marks the line bad. On the
// character flagged line_last the line is settled: a good line of exactly
// byte_count bytes is sent as that many results (status 0, last on the final
// byte), an empty good line sends nothing, and any other line sends one skip
// result (data_byte 0, status 1, last 1). After the line end the line is settled; each
// emitted byte is then read through the registered read port of the line buffer and
// loaded into the result register, or the skip result is loaded; a load waits while the
// result register is full, and text_in is held off meanwhile. byte_out has its own result
// register, so scanning of the next line goes on while the last result waits. byte_count
// is written through cfg, which is always ready; the user must write it only while the block
// is idle, which the block does not enforce; its reset value is 20.
module hex_line_to_binary_decoder #(
	parameter int unsigned MAX_BYTES = hld_pkg::MAX_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hld_text_if.sink   text_in,
	hld_byte_if.source byte_out,
	hld_cfg_if.sink    cfg
);
	import hld_pkg::*;

	logic [CFG_W-1:0] byte_count_q;
	hld_cmd_t         cmd;
	hld_stat_t        stat;

	// Configuration: take every request at once.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= BYTE_COUNT_RST;
		end else if (cfg.valid) begin
			byte_count_q <= cfg.byte_count;
		end
	end

	// Sequencer: accept characters, settle each line, pace the emit run.
	hld_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (text_in.valid),
		.in_line_last (text_in.line_last),
		.stat         (stat),
		.in_ready     (text_in.ready),
		.cmd          (cmd)
	);

	// Datapath: scan state, line buffer and result register.
	hld_dpath #(
		.MAX_BYTES (MAX_BYTES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.ch            (text_in.ch),
		.byte_count    (byte_count_q),
		.out_ready     (byte_out.ready),
		.stat          (stat),
		.out_valid     (byte_out.valid),
		.out_data_byte (byte_out.data_byte),
		.out_status    (byte_out.status),
		.out_last      (byte_out.last)
	);

endmodule
`default_nettype wire

// File: rtl/core/hld_ctrl.sv
// Line sequencer of the hex line decoder: scan, decide, emit bytes or skip.
`default_nettype none
module hld_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_line_last,
	input  var  hld_pkg::hld_stat_t stat,
	output logic                   in_ready,
	output hld_pkg::hld_cmd_t      cmd
);
	import hld_pkg::*;

	hld_state_t state_q;
	hld_state_t state_d;
	logic       in_fire;

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SCAN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SCAN: begin
				if (in_fire && in_line_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (stat.empty) begin
					state_d = ST_SCAN;
				end else if (stat.match) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_SKIP;
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (stat.out_free) begin
					state_d = stat.rd_last ? ST_SCAN : ST_READ;
				end
			end
			ST_SKIP: begin
				if (stat.out_free) begin
					state_d = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_SCAN;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_SCAN: begin
				in_ready = 1'b1;
				cmd.scan = in_valid;
			end
			ST_DECIDE: begin
				cmd.clear = stat.empty;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			ST_LOAD: begin
				cmd.load_byte = stat.out_free;
				cmd.clear     = stat.out_free && stat.rd_last;
			end
			ST_SKIP: begin
				cmd.load_skip = stat.out_free;
				cmd.clear     = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/hld_dpath.sv
// Datapath of the hex line decoder: scan registers, line buffer, result register.
`default_nettype none
module hld_dpath #(
	parameter int unsigned MAX_BYTES = hld_pkg::MAX_BYTES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  var  hld_pkg::hld_cmd_t         cmd,
	input  wire logic [7:0]                ch,
	input  wire logic [hld_pkg::CFG_W-1:0] byte_count,
	input  wire logic                      out_ready,
	output hld_pkg::hld_stat_t             stat,
	output logic                           out_valid,
	output logic [7:0]                     out_data_byte,
	output logic                           out_status,
	output logic                           out_last
);
	import hld_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);
	localparam int unsigned IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

	logic [7:0]       line_mem [MAX_BYTES];
	logic [7:0]       rd_data_q;
	logic [3:0]       hold_q;
	logic             half_q;
	logic [CNT_W-1:0] bytes_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             bad_q;
	logic             done_q;
	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic             out_status_q;
	logic             out_last_q;

	hex_digit_t       dig;
	logic             active;
	logic             full;
	logic             store;
	logic             good;
	logic [CNT_W-1:0] rd_next;

	assign dig     = hex_value(ch);
	assign active  = cmd.scan && !done_q;
	assign full    = (CFG_W'(bytes_q) >= byte_count) || (bytes_q >= MAX_CNT);
	assign store   = active && dig.is_hex && half_q && !full;
	assign good    = !bad_q && !half_q;
	assign rd_next = rd_idx_q + CNT_W'(1);

	assign stat.empty    = good && (bytes_q == '0);
	assign stat.match    = good && (CFG_W'(bytes_q) == byte_count);
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.rd_last  = (rd_next == bytes_q);

	// Line buffer: one write port for scanning, one registered read port for emitting.
	always_ff @(posedge clk) begin
		if (store) begin
			line_mem[bytes_q[IDX_W-1:0]] <= {hold_q, dig.nib};
		end
		if (cmd.rd_en) begin
			rd_data_q <= line_mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= '0;
			half_q   <= 1'b0;
			bytes_q  <= '0;
			bad_q    <= 1'b0;
			done_q   <= 1'b0;
			rd_idx_q <= '0;
		end else if (cmd.clear) begin
			hold_q   <= '0;
			half_q   <= 1'b0;
			bytes_q  <= '0;
			bad_q    <= 1'b0;
			done_q   <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.load_byte) begin
				rd_idx_q <= rd_next;
			end
			if (active) begin
				priority if (dig.is_hex) begin
					if (!half_q) begin
						hold_q <= dig.nib;
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						if (full) begin
							bad_q  <= 1'b1;
							done_q <= 1'b1;
						end else begin
							bytes_q <= bytes_q + CNT_W'(1);
							hold_q  <= '0;
						end
					end
				end else if (ch == CH_SPACE || ch == CH_TAB) begin
					// skip blanks
				end else if (ch == CH_NUL || (ch >= CH_LF && ch <= CH_CR)) begin
					done_q <= 1'b1;
				end else begin
					bad_q  <= 1'b1;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_byte || cmd.load_skip) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			out_data_q   <= rd_data_q;
			out_status_q <= 1'b0;
			out_last_q   <= stat.rd_last;
		end else if (cmd.load_skip) begin
			out_data_q   <= '0;
			out_status_q <= 1'b1;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data_byte = out_data_q;
	assign out_status    = out_status_q;
	assign out_last      = out_last_q;

endmodule
`default_nettype wire
